[hdl/fmtsg_pkg.sv]
// ----------------------------------------------------------------------------
// fmtsg_pkg: shared types and constants of the FM test-signal generator
// Holds the sequencer states, the configuration record, register indexes and
// the fixed constants of the sine polynomial and the noise generator.
// ----------------------------------------------------------------------------
package fmtsg_pkg;

  // Width of the shared multiplier operands.
  localparam int unsigned MUL_W = 32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TONE_STEP      = 2'd0,
    REG_DEVIATION_STEP = 2'd1,
    REG_NOISE_GAIN     = 2'd2,
    REG_SAMPLE_COUNT   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] tone_step;
    logic [31:0] deviation_step;
    logic [15:0] noise_gain;
    logic [31:0] sample_count;
  } cfg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_X2C,
    ST_T1,
    ST_T2,
    ST_FIN,
    ST_DEV,
    ST_CAR,
    ST_LCG1,
    ST_LCG2,
    ST_NMUL,
    ST_NSUM,
    ST_RND,
    ST_DONE
  } state_e;

  // Which sine evaluation is in flight.
  typedef enum logic [1:0] {
    SEL_AUDIO,
    SEL_COS,
    SEL_SIN
  } sine_sel_e;

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd691029450;
  localparam logic [31:0] SIN_C = 32'd78141561;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;

  // Linear congruential noise generator.
  localparam logic [31:0] NOISE_SEED = 32'h0123_4567;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

endpackage

[hdl/fmtsg_cfg.sv]
// ----------------------------------------------------------------------------
// fmtsg_cfg: configuration registers
// Decodes the write port and holds the four run settings.
// ----------------------------------------------------------------------------
module fmtsg_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  output fmtsg_pkg::cfg_t     cfg_o
);

  fmtsg_pkg::cfg_t cfg_q;
  fmtsg_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        fmtsg_pkg::REG_TONE_STEP:      cfg_d.tone_step = cfg_wdata_i;
        fmtsg_pkg::REG_DEVIATION_STEP: cfg_d.deviation_step = cfg_wdata_i;
        fmtsg_pkg::REG_NOISE_GAIN:     cfg_d.noise_gain = cfg_wdata_i[15:0];
        fmtsg_pkg::REG_SAMPLE_COUNT:   cfg_d.sample_count = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/fmtsg_mul.sv]
// ----------------------------------------------------------------------------
// fmtsg_mul: shared multiplier
// Unsigned 32 x 32 multiply with the full product registered.
// ----------------------------------------------------------------------------
module fmtsg_mul (
  input  logic                              clk_i,
  input  logic [fmtsg_pkg::MUL_W-1:0]       a_i,
  input  logic [fmtsg_pkg::MUL_W-1:0]       b_i,
  output logic [2*fmtsg_pkg::MUL_W-1:0]     p_o
);

  logic [2*fmtsg_pkg::MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*fmtsg_pkg::MUL_W)'(a_i) * (2*fmtsg_pkg::MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

[hdl/fm_test_signal_generator.sv]
// ----------------------------------------------------------------------------
// fm_test_signal_generator: FM carrier I/Q test source with additive noise
// Each input item (restart flag) yields at most one I/Q sample of a DDS FM
// carrier plus pseudo-random noise.
//
// Usage: write tone_step, deviation_step, noise_gain and sample_count through
// the configuration port while the block is idle, then send items on the
// in_valid_i/in_ready_o channel. An item with restart_i set clears both phase
// accumulators and the sample counter and reseeds the noise generator first.
// Once sample_count samples have been produced, items are taken but give no
// result until a restart. The final sample of a run carries last_o.
// Busy period: a producing item keeps the block busy after acceptance, so the
// next item is not taken until that sample is done; the sample is loaded
// into the output register at the edge where in_ready_o rises again. An item
// that gives no sample is taken without leaving idle. The busy period comes
// from the single registered multiplier, which performs every sine
// polynomial term, the deviation product and the noise steps in turn.
// A sample waits in the output register while out_ready_i is low; a new item
// is accepted meanwhile, and its result is held back until the slot is free.
// Reset clears the control registers and out_valid, both phases and the counter, and reseeds noise.
// ----------------------------------------------------------------------------
module fm_test_signal_generator #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned OUT_BITS        = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [31:0]                cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [OUT_BITS-1:0] i_sample_o,
  output logic signed [OUT_BITS-1:0] q_sample_o,
  output logic                       last_o
);

  localparam int unsigned QA = TABLE_ADDR_BITS - 2;
  localparam int unsigned SH = 32 - OUT_BITS;
  localparam int unsigned RW = 36;
  localparam logic [TABLE_ADDR_BITS-1:0] QUARTER = TABLE_ADDR_BITS'(1) << QA;
  localparam logic signed [RW-1:0] RND_HALF = RW'(1 << (SH - 1));
  localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(1 << (OUT_BITS - 1)));

  fmtsg_pkg::cfg_t cfg;

  fmtsg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] p_q;

  fmtsg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (p_q)
  );

  fmtsg_pkg::state_e state_q, state_d;
  fmtsg_pkg::sine_sel_e sel_q, sel_d;
  logic nq_q, nq_d;

  logic [PHASE_BITS-1:0] audio_phase_q, audio_phase_d;
  logic [PHASE_BITS-1:0] carrier_phase_q, carrier_phase_d;
  logic [31:0] noise_state_q, noise_state_d;
  logic [31:0] sample_index_q, sample_index_d;

  logic [30:0] x_q, x_d;
  logic [30:0] x2_q, x2_d;
  logic neg_q, neg_d;
  logic [30:0] amag_q, amag_d;
  logic aneg_q, aneg_d;
  logic signed [31:0] cos_q, cos_d;
  logic signed [31:0] sin_q, sin_d;
  logic signed [RW-1:0] sum_q, sum_d;
  logic [OUT_BITS-1:0] res_i_q, res_i_d;

  logic out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0] out_i_q, out_i_d;
  logic [OUT_BITS-1:0] out_q_q, out_q_d;
  logic out_last_q, out_last_d;

  logic [31:0] eff_index;
  logic run_ok;
  logic out_free;
  logic [TABLE_ADDR_BITS-1:0] audio_addr;
  logic [TABLE_ADDR_BITS-1:0] car_addr;
  logic [TABLE_ADDR_BITS-1:0] ld_addr;
  logic [30:0] x_raw;
  logic [30:0] x_ld;
  logic [30:0] fin_v;
  logic signed [31:0] fin_s;
  logic [63:0] car_round;
  logic [PHASE_BITS-1:0] car_inc;
  logic signed [RW-1:0] rnd;
  logic [OUT_BITS-1:0] sat;

  // Address, sine and rounding helpers shared by several states.
  always_comb begin
    eff_index = restart_i ? 32'd0 : sample_index_q;
    run_ok = eff_index < cfg.sample_count;
    out_free = !out_valid_q || out_ready_i;

    audio_addr = audio_phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    car_addr = carrier_phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    case (sel_q)
      fmtsg_pkg::SEL_AUDIO: ld_addr = audio_addr;
      fmtsg_pkg::SEL_COS:   ld_addr = car_addr + QUARTER;
      fmtsg_pkg::SEL_SIN:   ld_addr = car_addr;
      default:              ld_addr = audio_addr;
    endcase
    // Odd quadrants run the quarter wave mirrored.
    x_raw = 31'(ld_addr[QA-1:0]) << (30 - QA);
    x_ld = ld_addr[QA] ? (fmtsg_pkg::Q30_ONE - x_raw) : x_raw;

    fin_v = p_q[60:30];
    fin_s = neg_q ? -$signed({1'b0, fin_v}) : $signed({1'b0, fin_v});

    car_round = p_q + fmtsg_pkg::HALF_Q30;
    car_inc = PHASE_BITS'(car_round[62:30]);

    rnd = (sum_q + RND_HALF) >>> SH;
    if (rnd > SAT_HI) begin
      sat = SAT_HI[OUT_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[OUT_BITS-1:0];
    end else begin
      sat = rnd[OUT_BITS-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmtsg_pkg::ST_IDLE: begin
        if (in_valid_i && run_ok) state_d = fmtsg_pkg::ST_LOAD;
      end
      fmtsg_pkg::ST_LOAD: state_d = fmtsg_pkg::ST_SQ;
      fmtsg_pkg::ST_SQ:   state_d = fmtsg_pkg::ST_X2C;
      fmtsg_pkg::ST_X2C:  state_d = fmtsg_pkg::ST_T1;
      fmtsg_pkg::ST_T1:   state_d = fmtsg_pkg::ST_T2;
      fmtsg_pkg::ST_T2:   state_d = fmtsg_pkg::ST_FIN;
      fmtsg_pkg::ST_FIN: begin
        case (sel_q)
          fmtsg_pkg::SEL_AUDIO: state_d = fmtsg_pkg::ST_DEV;
          fmtsg_pkg::SEL_COS:   state_d = fmtsg_pkg::ST_LOAD;
          default:              state_d = fmtsg_pkg::ST_LCG1;
        endcase
      end
      fmtsg_pkg::ST_DEV:  state_d = fmtsg_pkg::ST_CAR;
      fmtsg_pkg::ST_CAR:  state_d = fmtsg_pkg::ST_LOAD;
      fmtsg_pkg::ST_LCG1: state_d = fmtsg_pkg::ST_LCG2;
      fmtsg_pkg::ST_LCG2: state_d = fmtsg_pkg::ST_NMUL;
      fmtsg_pkg::ST_NMUL: state_d = fmtsg_pkg::ST_NSUM;
      fmtsg_pkg::ST_NSUM: state_d = fmtsg_pkg::ST_RND;
      fmtsg_pkg::ST_RND:  state_d = nq_q ? fmtsg_pkg::ST_DONE : fmtsg_pkg::ST_LCG1;
      fmtsg_pkg::ST_DONE: begin
        if (out_free) state_d = fmtsg_pkg::ST_IDLE;
      end
      default: state_d = fmtsg_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls, multiplier operands and register next values.
  always_comb begin
    in_ready_o = 1'b0;
    mul_a = 32'd0;
    mul_b = 32'd0;
    sel_d = sel_q;
    nq_d = nq_q;
    audio_phase_d = audio_phase_q;
    carrier_phase_d = carrier_phase_q;
    noise_state_d = noise_state_q;
    sample_index_d = sample_index_q;
    x_d = x_q;
    x2_d = x2_q;
    neg_d = neg_q;
    amag_d = amag_q;
    aneg_d = aneg_q;
    cos_d = cos_q;
    sin_d = sin_q;
    sum_d = sum_q;
    res_i_d = res_i_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_i_d = out_i_q;
    out_q_d = out_q_q;
    out_last_d = out_last_q;

    case (state_q)
      fmtsg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        sel_d = fmtsg_pkg::SEL_AUDIO;
        nq_d = 1'b0;
        if (in_valid_i && restart_i) begin
          audio_phase_d = '0;
          carrier_phase_d = '0;
          sample_index_d = 32'd0;
          noise_state_d = fmtsg_pkg::NOISE_SEED;
        end
      end
      fmtsg_pkg::ST_LOAD: begin
        x_d = x_ld;
        neg_d = ld_addr[TABLE_ADDR_BITS-1];
        if (sel_q == fmtsg_pkg::SEL_AUDIO) begin
          audio_phase_d = audio_phase_q + PHASE_BITS'(cfg.tone_step);
        end
      end
      fmtsg_pkg::ST_SQ: begin
        mul_a = {1'b0, x_q};
        mul_b = {1'b0, x_q};
      end
      fmtsg_pkg::ST_X2C: begin
        x2_d = p_q[60:30];
        mul_a = {1'b0, p_q[60:30]};
        mul_b = fmtsg_pkg::SIN_C;
      end
      fmtsg_pkg::ST_T1: begin
        mul_a = {1'b0, x2_q};
        mul_b = fmtsg_pkg::SIN_B - p_q[61:30];
      end
      fmtsg_pkg::ST_T2: begin
        mul_a = {1'b0, x_q};
        mul_b = fmtsg_pkg::SIN_A - p_q[61:30];
      end
      fmtsg_pkg::ST_FIN: begin
        case (sel_q)
          fmtsg_pkg::SEL_AUDIO: begin
            amag_d = fin_v;
            aneg_d = neg_q;
          end
          fmtsg_pkg::SEL_COS: begin
            cos_d = fin_s;
            sel_d = fmtsg_pkg::SEL_SIN;
          end
          default: sin_d = fin_s;
        endcase
      end
      fmtsg_pkg::ST_DEV: begin
        mul_a = {1'b0, amag_q};
        mul_b = cfg.deviation_step;
      end
      fmtsg_pkg::ST_CAR: begin
        carrier_phase_d = aneg_q ? (carrier_phase_q - car_inc) : (carrier_phase_q + car_inc);
        sel_d = fmtsg_pkg::SEL_COS;
      end
      fmtsg_pkg::ST_LCG1: begin
        mul_a = noise_state_q;
        mul_b = fmtsg_pkg::LCG_MUL;
      end
      fmtsg_pkg::ST_LCG2: begin
        noise_state_d = p_q[31:0] + fmtsg_pkg::LCG_ADD;
      end
      fmtsg_pkg::ST_NMUL: begin
        mul_a = {16'd0, noise_state_q[31:16]};
        mul_b = {16'd0, cfg.noise_gain};
      end
      fmtsg_pkg::ST_NSUM: begin
        // Centering the top half subtracts 32768 times the gain.
        sum_d = RW'(nq_q ? sin_q : cos_q) + RW'(p_q[31:0])
              - RW'({cfg.noise_gain, 15'd0});
      end
      fmtsg_pkg::ST_RND: begin
        res_i_d = nq_q ? res_i_q : sat;
        nq_d = 1'b1;
      end
      fmtsg_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_i_d = res_i_q;
          out_q_d = sat;
          out_last_d = (sample_index_q + 32'd1) == cfg.sample_count;
          sample_index_d = sample_index_q + 32'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmtsg_pkg::ST_IDLE;
      sel_q <= fmtsg_pkg::SEL_AUDIO;
      nq_q <= 1'b0;
      audio_phase_q <= '0;
      carrier_phase_q <= '0;
      noise_state_q <= fmtsg_pkg::NOISE_SEED;
      sample_index_q <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q <= sel_d;
      nq_q <= nq_d;
      audio_phase_q <= audio_phase_d;
      carrier_phase_q <= carrier_phase_d;
      noise_state_q <= noise_state_d;
      sample_index_q <= sample_index_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    x2_q <= x2_d;
    neg_q <= neg_d;
    amag_q <= amag_d;
    aneg_q <= aneg_d;
    cos_q <= cos_d;
    sin_q <= sin_d;
    sum_q <= sum_d;
    res_i_q <= res_i_d;
    out_i_q <= out_i_d;
    out_q_q <= out_q_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign i_sample_o = out_i_q;
  assign q_sample_o = out_q_q;
  assign last_o = out_last_q;

endmodule
